// ----- design/icv_pkg.sv -----
// ----------------------------------------------------------------------------
// icv_pkg: shared constants, types and helpers for the 3x3 image filter
// Holds the geometry limits, register indexes and the kernel lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package icv_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int AddrW     = $clog2(MaxWidth);
	localparam int GeomW     = 11;
	localparam int PosW      = 10;
	localparam int PixW      = 8;
	localparam int AccW      = 20;
	localparam int DivW      = 19;
	localparam int DsrW      = 12;
	localparam int DivCntW   = $clog2(DivW + 1);
	localparam int NumTaps   = 9;
	localparam int TapW      = 4;

	localparam logic [2:0] RegKernelTop    = 3'd0;
	localparam logic [2:0] RegKernelMiddle = 3'd1;
	localparam logic [2:0] RegKernelBottom = 3'd2;
	localparam logic [2:0] RegDivisor      = 3'd3;
	localparam logic [2:0] RegFrameWidth   = 3'd4;
	localparam logic [2:0] RegFrameHeight  = 3'd5;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// Coefficient for window tap 0..8 (row-major), column 0 in the low byte.
	function automatic logic signed [7:0] kernel_coef(
		input logic [23:0]     top,
		input logic [23:0]     mid,
		input logic [23:0]     bot,
		input logic [TapW-1:0] tap
	);
		logic [7:0] b;
		case (tap)
			4'd0:    b = top[7:0];
			4'd1:    b = top[15:8];
			4'd2:    b = top[23:16];
			4'd3:    b = mid[7:0];
			4'd4:    b = mid[15:8];
			4'd5:    b = mid[23:16];
			4'd6:    b = bot[7:0];
			4'd7:    b = bot[15:8];
			4'd8:    b = bot[23:16];
			default: b = 8'd0;
		endcase
		return $signed(b);
	endfunction

endpackage

`default_nettype wire

// ----- design/icv_divider.sv -----
// ----------------------------------------------------------------------------
// icv_divider: restoring unsigned divider, one quotient bit per cycle
// Divides a positive weighted sum by the configured divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module icv_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [icv_pkg::DivW-1:0]   dividend,
	input  wire logic [icv_pkg::DsrW-1:0]   dsr,
	output icv_pkg::div_status_t            status,
	output logic      [icv_pkg::DivW-1:0]   quotient
);

	logic [icv_pkg::DsrW:0]        rem_q;
	logic [icv_pkg::DivW-1:0]      quo_q;
	logic [icv_pkg::DsrW-1:0]      dsr_q;
	logic [icv_pkg::DivCntW-1:0]   cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [icv_pkg::DsrW:0]        trial;
	logic                          fits;

	assign trial = {rem_q[icv_pkg::DsrW-1:0], quo_q[icv_pkg::DivW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == icv_pkg::DivCntW'(icv_pkg::DivW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= dsr;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
			quo_q <= {quo_q[icv_pkg::DivW-2:0], fits};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

`default_nettype wire

// ----- design/image_convolution_3x3.sv -----
// ----------------------------------------------------------------------------
// image_convolution_3x3: streaming 3x3 convolution over one 8-bit plane
// Line memory, window, serial multiply-accumulate and iterative divide.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the input channel (in_valid/in_stall); one
// beat carries one pixel. The block holds in_stall high while it works on a
// pixel. Every pixel passes through a read of the line memory at its column
// and a write-back with the window shift. An interior pixel then runs a
// multiply-accumulate over the nine taps through one shared multiplier and,
// for a positive sum, the restoring divider, whose quotient it then picks up;
// a border pixel occupies the block only for the read and the write-back.
// Results leave through an output register (out_valid/out_stall) carrying the
// filtered value, its row and column and a flag on the last interior pixel.
// A stalled result is held; the next pixel is taken meanwhile and waits only
// when its own result is ready to be loaded.
// Reset clears the window, the position counters and the registers to their
// defaults; the line memory is not cleared, as only the first two rows of the
// first plane read it before they write it and no result depends on it.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module image_convolution_3x3 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  pixel_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       result_value,
	output logic [9:0]       out_row,
	output logic [9:0]       out_col,
	output logic             frame_done
);

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StShift = 3'd1;
	localparam logic [2:0] StMac   = 3'd2;
	localparam logic [2:0] StDiv   = 3'd3;
	localparam logic [2:0] StOut   = 3'd4;

	localparam int GW = icv_pkg::GeomW;
	localparam int PW = icv_pkg::PosW;

	logic [23:0]               ktop_q, kmid_q, kbot_q;
	logic [icv_pkg::DsrW-1:0]  divisor_q;
	logic [GW-1:0]             fwidth_q, fheight_q;

	logic [2:0]                state_q;
	logic [PW-1:0]             col_q, row_q;
	logic [7:0]                px_q;
	logic [7:0]                win_q [icv_pkg::NumTaps];
	logic [icv_pkg::TapW-1:0]  tap_q;
	logic signed [icv_pkg::AccW-1:0] acc_q;
	logic [7:0]                res_q;
	logic [PW-1:0]             orow_q, ocol_q;
	logic                      odone_q;

	logic [15:0]               line_mem [icv_pkg::MaxWidth];
	logic [15:0]               mem_rd_q;

	logic [GW-1:0]             w_eff, h_eff;
	logic [GW-1:0]             c_ext, r_ext;
	logic                      produce;
	logic                      accept;
	logic                      out_free;
	logic signed [16:0]        product;
	logic signed [icv_pkg::AccW-1:0] acc_next;
	logic                      div_start;
	icv_pkg::div_status_t      div_st;
	logic [icv_pkg::DivW-1:0]  quotient;
	logic [icv_pkg::DsrW-1:0]  dsr_eff;

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ktop_q    <= 24'h000000;
			kmid_q    <= 24'h010000;
			kbot_q    <= 24'h000000;
			divisor_q <= 12'd1;
			fwidth_q  <= GW'(icv_pkg::MaxWidth);
			fheight_q <= GW'(icv_pkg::MaxHeight);
		end else if (cfg_we) begin
			case (cfg_index)
				icv_pkg::RegKernelTop:    ktop_q    <= cfg_wdata;
				icv_pkg::RegKernelMiddle: kmid_q    <= cfg_wdata;
				icv_pkg::RegKernelBottom: kbot_q    <= cfg_wdata;
				icv_pkg::RegDivisor:      divisor_q <= cfg_wdata[icv_pkg::DsrW-1:0];
				icv_pkg::RegFrameWidth:   fwidth_q  <= cfg_wdata[GW-1:0];
				icv_pkg::RegFrameHeight:  fheight_q <= cfg_wdata[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fwidth_q < GW'(3))
			w_eff = GW'(3);
		else if (fwidth_q > GW'(icv_pkg::MaxWidth))
			w_eff = GW'(icv_pkg::MaxWidth);
		else
			w_eff = fwidth_q;
		if (fheight_q < GW'(3))
			h_eff = GW'(3);
		else if (fheight_q > GW'(icv_pkg::MaxHeight))
			h_eff = GW'(icv_pkg::MaxHeight);
		else
			h_eff = fheight_q;
	end

	assign dsr_eff  = (divisor_q == '0) ? icv_pkg::DsrW'(1) : divisor_q;
	assign c_ext    = {1'b0, col_q};
	assign r_ext    = {1'b0, row_q};
	assign produce  = (row_q >= PW'(2)) && (col_q >= PW'(2)) && (r_ext < h_eff) && (c_ext < w_eff);
	assign in_stall = (state_q != StIdle);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// Line memory: high byte is the older row, low byte the newer row.
	always_ff @(posedge clk) begin
		if (accept)
			mem_rd_q <= line_mem[col_q[icv_pkg::AddrW-1:0]];
		if (state_q == StShift)
			line_mem[col_q[icv_pkg::AddrW-1:0]] <= {mem_rd_q[7:0], px_q};
	end

	assign product  = $signed({1'b0, win_q[tap_q]})
	                * icv_pkg::kernel_coef(ktop_q, kmid_q, kbot_q, tap_q);
	assign acc_next = acc_q + icv_pkg::AccW'(product);
	assign div_start = (state_q == StMac) && (tap_q == icv_pkg::TapW'(icv_pkg::NumTaps - 1))
	                 && (acc_next > 0);

	icv_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_next[icv_pkg::DivW-1:0]),
		.dsr      (dsr_eff),
		.status   (div_st),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			col_q     <= '0;
			row_q     <= '0;
			tap_q     <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < icv_pkg::NumTaps; i++)
				win_q[i] <= '0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				StIdle: begin
					if (accept)
						state_q <= StShift;
				end
				StShift: begin
					for (int i = 0; i < 3; i++) begin
						win_q[i*3]     <= win_q[i*3 + 1];
						win_q[i*3 + 1] <= win_q[i*3 + 2];
					end
					win_q[2] <= mem_rd_q[15:8];
					win_q[5] <= mem_rd_q[7:0];
					win_q[8] <= px_q;
					if (c_ext + GW'(1) >= w_eff) begin
						col_q <= '0;
						row_q <= (r_ext + GW'(1) >= h_eff) ? '0 : row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
					tap_q   <= '0;
					state_q <= produce ? StMac : StIdle;
				end
				StMac: begin
					tap_q <= tap_q + 1'b1;
					if (tap_q == icv_pkg::TapW'(icv_pkg::NumTaps - 1))
						state_q <= (acc_next > 0) ? StDiv : StOut;
				end
				StDiv: begin
					if (div_st.done)
						state_q <= StOut;
				end
				StOut: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			px_q <= pixel_value;
		if (state_q == StShift) begin
			acc_q   <= '0;
			orow_q  <= row_q - 1'b1;
			ocol_q  <= col_q - 1'b1;
			odone_q <= (r_ext == h_eff - GW'(1)) && (c_ext == w_eff - GW'(1));
		end
		if (state_q == StMac) begin
			acc_q <= acc_next;
			// A sum at or below zero truncates to a quotient that clamps to zero.
			if (tap_q == icv_pkg::TapW'(icv_pkg::NumTaps - 1))
				res_q <= 8'd0;
		end
		if (state_q == StDiv && div_st.done)
			res_q <= (quotient[icv_pkg::DivW-1:8] != '0) ? 8'd255 : quotient[7:0];
		if (state_q == StOut && out_free) begin
			result_value <= res_q;
			out_row      <= orow_q;
			out_col      <= ocol_q;
			frame_done   <= odone_q;
		end
	end

endmodule

`default_nettype wire

// ----- design/icv_checker.sv -----
// ----------------------------------------------------------------------------
// icv_checker: port-level checks for the 3x3 image filter
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module icv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] result_value,
	input wire logic [9:0] out_row,
	input wire logic [9:0] out_col,
	input wire logic       frame_done
);

	// A result beat that is held back keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value)
		&& $stable(out_row) && $stable(out_col) && $stable(frame_done))
		else $error("stalled result changed");

	// The block never takes pixel beats back to back; each accepted beat raises in_stall.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");

	// A new result only appears while the block is busy with its pixel.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

	// Results are interior pixels only.
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_row != 10'd0 && out_col != 10'd0)
		else $error("border position reported");

endmodule

bind image_convolution_3x3 icv_checker u_icv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_value (result_value),
	.out_row      (out_row),
	.out_col      (out_col),
	.frame_done   (frame_done)
);

`default_nettype wire

// ----- dv/tb_image_convolution_3x3.sv -----
// ----------------------------------------------------------------------------
// tb_image_convolution_3x3: self-checking bench for the 3x3 image filter
// Streams pixel planes of several geometries and kernels through the block,
// predicts every interior result in a scoreboard and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class conv_scoreboard;
	logic [23:0] krow [3];
	logic [11:0] dsr;
	logic [10:0] fwidth, fheight;
	logic [7:0]  older [1024];
	logic [7:0]  newer [1024];
	logic [7:0]  win [9];
	int unsigned col, row;
	logic [28:0] pending [$];
	int          errors;
	int          checked;

	function new();
		krow[0] = 24'h0;
		krow[1] = 24'h010000;
		krow[2] = 24'h0;
		dsr = 12'd1;
		fwidth = 11'd1024;
		fheight = 11'd1024;
		foreach (win[i]) win[i] = 8'd0;
		foreach (older[i]) begin
			older[i] = 8'd0;
			newer[i] = 8'd0;
		end
		col = 0;
		row = 0;
		errors = 0;
		checked = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [23:0] val);
		case (idx)
			icv_pkg::RegKernelTop:    krow[0] = val;
			icv_pkg::RegKernelMiddle: krow[1] = val;
			icv_pkg::RegKernelBottom: krow[2] = val;
			icv_pkg::RegDivisor:      dsr = val[11:0];
			icv_pkg::RegFrameWidth:   fwidth = val[10:0];
			icv_pkg::RegFrameHeight:  fheight = val[10:0];
			default: ;
		endcase
	endfunction

	// Notes one accepted pixel and queues the filtered result it releases.
	function void note_pixel(logic [7:0] px);
		int unsigned w, h;
		logic [7:0] up, mid;
		int sum, d, q;
		logic [7:0] coef;
		w = fwidth < 3 ? 3 : (fwidth > 1024 ? 1024 : fwidth);
		h = fheight < 3 ? 3 : (fheight > 1024 ? 1024 : fheight);
		up = 8'd0;
		mid = 8'd0;
		if (col < 1024) begin
			up = older[col];
			mid = newer[col];
			older[col] = mid;
			newer[col] = px;
		end
		for (int i = 0; i < 3; i++) begin
			win[i*3] = win[i*3+1];
			win[i*3+1] = win[i*3+2];
		end
		win[2] = up;
		win[5] = mid;
		win[8] = px;
		if (row >= 2 && col >= 2 && row < h && col < w) begin
			sum = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					coef = krow[i][8*j +: 8];
					sum += int'(win[i*3+j]) * int'($signed(coef));
				end
			d = (dsr == 0) ? 1 : int'(dsr);
			q = sum / d;
			if (q < 0) q = 0;
			if (q > 255) q = 255;
			pending.push_back({q[7:0], 10'(row - 1), 10'(col - 1),
				(row == h - 1 && col == w - 1) ? 1'b1 : 1'b0});
		end
		if (col + 1 >= w) begin
			col = 0;
			row = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col = col + 1;
		end
	endfunction

	function void check_result(logic [7:0] v, logic [9:0] r, logic [9:0] c, logic fd);
		logic [28:0] e;
		checked++;
		if (pending.size() == 0) begin
			report("result with none expected", 0, {v, r, c, fd});
			return;
		end
		e = pending.pop_front();
		if (e[28:21] != v) report("result_value", e[28:21], v);
		if (e[20:11] != r) report("out_row", e[20:11], r);
		if (e[10:1] != c) report("out_col", e[10:1], c);
		if (e[0] != fd) report("frame_done", e[0], fd);
	endfunction

	function void report(string what, int exp_v, int got_v);
		errors++;
		if (errors <= 40)
			$display("MISMATCH %s: expected %0d got %0d", what, exp_v, got_v);
	endfunction
endclass

module tb_image_convolution_3x3;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  pixel_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  result_value;
	logic [9:0]  out_row, out_col;
	logic        frame_done;

	conv_scoreboard sb = new();
	int send_idle = 0, recv_idle = 0;
	int hold_off = 0;
	longint cycles = 0;
	int pixels_sent = 0;

	image_convolution_3x3 DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("timeout");
			$display("tb_image_convolution_3x3 NOT OK");
			$finish;
		end
	end

	// Receiver: random stall, or a long hold-off when requested.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result_value, out_row, out_col, frame_done);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Offers one beat, holding it until the block takes it.
	task automatic send_pixel(logic [7:0] px);
		while ($urandom_range(99) < send_idle) begin
			@(posedge clk);
			in_valid <= 1'b0;
		end
		@(posedge clk);
		in_valid <= 1'b1;
		pixel_value <= px;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(px);
		pixels_sent++;
		in_valid <= 1'b0;
	endtask

	// The block takes each beat through a read and a write-back, so dropping valid after each beat costs nothing.
	task automatic send_frame(int n, int mode);
		logic [7:0] p;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: p = 8'($urandom_range(255));
				1: p = ($urandom_range(1)) ? 8'hFF : 8'h00;
				default: p = i[7:0];
			endcase
			send_pixel(p);
		end
	endtask

	task automatic setup(int w, int h, logic [23:0] kt, logic [23:0] km,
			logic [23:0] kb, int d);
		write_cfg(icv_pkg::RegKernelTop, kt);
		write_cfg(icv_pkg::RegKernelMiddle, km);
		write_cfg(icv_pkg::RegKernelBottom, kb);
		write_cfg(icv_pkg::RegDivisor, 24'(d));
		write_cfg(icv_pkg::RegFrameWidth, 24'(w));
		write_cfg(icv_pkg::RegFrameHeight, 24'(h));
	endtask

	initial begin
		int w, h;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: minimum frames, extreme kernels, divisor zero and maximum.
		setup(3, 3, 24'h010101, 24'h010101, 24'h010101, 9);
		send_frame(9, 2);
		drain();
		setup(3, 3, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 0);
		send_frame(9, 1);
		drain();
		setup(4, 3, 24'h808080, 24'h808080, 24'h808080, 4095);
		send_frame(12, 1);
		drain();
		// Out-of-range geometry is held to the limits.
		setup(0, 2047, 24'hFF00FF, 24'h04FC01, 24'h80017F, 1);
		send_frame(15, 0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 29 : (ph == 1 ? 76 : 0);
			recv_idle = (ph == 0) ? 76 : (ph == 1 ? 29 : 0);
			for (int f = 0; f < 6; f++) begin
				drain();
				w = $urandom_range(3, 12);
				h = $urandom_range(3, 9);
				setup(w, h, 24'($urandom), 24'($urandom), 24'($urandom),
					$urandom_range(1, 40));
				// The receiver holds off while the frame is still being offered.
				if (f == 2) hold_off = 400;
				send_frame(w * h, f % 2);
			end
		end
		// Long rows with a short frame, then a mid-frame geometry change.
		drain();
		setup(256, 3, 24'h000000, 24'h010000, 24'h000000, 1);
		send_frame(256 * 3, 0);
		drain();
		setup(8, 8, 24'h01FF01, 24'h02FE02, 24'h01FF01, 3);
		send_frame(20, 0);
		drain();
		write_cfg(icv_pkg::RegFrameWidth, 24'd5);
		write_cfg(icv_pkg::RegFrameHeight, 24'd4);
		send_frame(40, 0);
		drain();
		repeat (100) @(posedge clk);
		$display("Sent %0d pixels over several geometries and kernels; checked %0d results.",
			pixels_sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_image_convolution_3x3 OK");
		else
			$display("tb_image_convolution_3x3 NOT OK");
		$finish;
	end
endmodule

`default_nettype wire

// ----- sim.f -----
design/icv_pkg.sv
design/icv_divider.sv
design/image_convolution_3x3.sv
design/icv_checker.sv
dv/tb_image_convolution_3x3.sv
